### hw/rtl/scd_pkg.sv
// Shared widths, reset values, register codes, types and helpers of the step cadence detector.
package scd_pkg;

   localparam int SAMPLE_W = 12;
   localparam int OFFSET_W = 12;
   localparam int WORD_W   = 16;
   localparam int TIME_W   = 32;
   localparam int INDEX_W  = 3;

   localparam int HISTORY_DEPTH_DEF = 5;
   localparam int ADC_BITS_DEF      = 12;

   localparam int DIFF_W   = 13;
   localparam int PROD_W   = 30;
   localparam int SCALED_W = 25;
   localparam int WIDE_W   = 26;
   localparam int MIX_W    = 38;
   localparam int DELTA_W  = 17;
   localparam int SQ_W     = 33;
   localparam int DSQ_W    = 34;
   localparam int DECAY_W  = 48;
   localparam int QUOT_W   = 22;
   localparam int COUNT_W  = 5;

   localparam logic [QUOT_W-1:0]  RATE_NUM    = 22'd4096000;
   localparam logic [DECAY_W-1:0] DECAY_LIMIT = 48'd4096000;
   localparam logic [12:0]        COS30_Q12   = 13'd3547;
   localparam logic [9:0]         FIFTH_Q12   = 10'd819;
   localparam logic [14:0]        HALF_Q12    = 15'd2048;

   localparam logic [OFFSET_W-1:0] OFFSET_RIGHT_RST = 12'd104;
   localparam logic [OFFSET_W-1:0] OFFSET_LEFT_RST  = 12'd150;
   localparam logic [OFFSET_W-1:0] OFFSET_FRONT_RST = 12'd60;
   localparam logic [WORD_W-1:0]   GAIN_RIGHT_RST   = 16'd285;
   localparam logic [WORD_W-1:0]   GAIN_LEFT_RST    = 16'd262;
   localparam logic [WORD_W-1:0]   GAIN_FRONT_RST   = 16'd328;
   localparam logic [WORD_W-1:0]   THRESHOLD_RST    = 16'd41;
   localparam logic [WORD_W-1:0]   MIN_INTERVAL_RST = 16'd300;

   typedef enum logic [INDEX_W-1:0] {
      REG_OFFSET_RIGHT,
      REG_OFFSET_LEFT,
      REG_OFFSET_FRONT,
      REG_GAIN_RIGHT,
      REG_GAIN_LEFT,
      REG_GAIN_FRONT,
      REG_MOVE_THRESHOLD_SQ,
      REG_MIN_INTERVAL_MS
   } reg_index_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset_right;
      logic [OFFSET_W-1:0] offset_left;
      logic [OFFSET_W-1:0] offset_front;
      logic [WORD_W-1:0]   gain_right;
      logic [WORD_W-1:0]   gain_left;
      logic [WORD_W-1:0]   gain_front;
      logic [WORD_W-1:0]   move_threshold_sq;
      logic [WORD_W-1:0]   min_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic scale;
      logic mix;
      logic point;
      logic square;
      logic decide;
      logic start_div;
      logic speed_a;
      logic speed_v;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic step_now;
      logic div_done;
   } status_type;

   function automatic logic signed [WORD_W-1:0] sat16s(input logic signed [WIDE_W-1:0] v);
      if (v > 26'sd32767) begin
         return 16'sd32767;
      end else if (v < -26'sd32768) begin
         return -16'sd32768;
      end else begin
         return $signed(v[WORD_W-1:0]);
      end
   endfunction

   function automatic logic [WORD_W-1:0] sat16u(input logic [18:0] v);
      if (v[18:WORD_W] != 3'd0) begin
         return 16'hffff;
      end else begin
         return v[WORD_W-1:0];
      end
   endfunction

endpackage

### hw/rtl/step_cadence_detector_unit.sv
// Top level of the step cadence detector: register file, controller and datapath.
//
//   channel  direction  transfer when          carries
//   req_     in         req_valid & !req_stall three ADC samples, now_ms
//   rsp_     out        rsp_valid & !rsp_stall step_seen, step_total, walk_speed
//   csr_     in         csr_valid & csr_ready  csr_index, csr_wdata
//
// An item without a step runs scale, mix, point, square and decide, then commit; an item
// counting a step also runs the bit-serial cadence divider (22 quotient bits) and speed states.
// The next item is taken while the previous result waits on rsp_stall; it finishes
// only once that result has been taken. Synchronous reset restores register defaults,
// clears history, counter, cadence and speed; no clearing pass is needed.
module step_cadence_detector_unit #(
   parameter int HISTORY_DEPTH = scd_pkg::HISTORY_DEPTH_DEF,
   parameter int ADC_BITS      = scd_pkg::ADC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [scd_pkg::SAMPLE_W-1:0]     req_right_sample,
   input  logic [scd_pkg::SAMPLE_W-1:0]     req_left_sample,
   input  logic [scd_pkg::SAMPLE_W-1:0]     req_front_sample,
   input  logic [scd_pkg::TIME_W-1:0]       req_now_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_step_seen,
   output logic [scd_pkg::WORD_W-1:0]       rsp_step_total,
   output logic [scd_pkg::WORD_W-1:0]       rsp_walk_speed,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [scd_pkg::INDEX_W-1:0]      csr_index,
   input  logic [scd_pkg::WORD_W-1:0]       csr_wdata
);

   scd_pkg::cfg_type    cfg_ff;
   scd_pkg::cmd_type    cmd;
   scd_pkg::status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_right      <= scd_pkg::OFFSET_RIGHT_RST;
         cfg_ff.offset_left       <= scd_pkg::OFFSET_LEFT_RST;
         cfg_ff.offset_front      <= scd_pkg::OFFSET_FRONT_RST;
         cfg_ff.gain_right        <= scd_pkg::GAIN_RIGHT_RST;
         cfg_ff.gain_left         <= scd_pkg::GAIN_LEFT_RST;
         cfg_ff.gain_front        <= scd_pkg::GAIN_FRONT_RST;
         cfg_ff.move_threshold_sq <= scd_pkg::THRESHOLD_RST;
         cfg_ff.min_interval_ms   <= scd_pkg::MIN_INTERVAL_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (scd_pkg::reg_index_type'(csr_index))
            scd_pkg::REG_OFFSET_RIGHT: begin
               cfg_ff.offset_right <= csr_wdata[scd_pkg::OFFSET_W-1:0];
            end
            scd_pkg::REG_OFFSET_LEFT: begin
               cfg_ff.offset_left <= csr_wdata[scd_pkg::OFFSET_W-1:0];
            end
            scd_pkg::REG_OFFSET_FRONT: begin
               cfg_ff.offset_front <= csr_wdata[scd_pkg::OFFSET_W-1:0];
            end
            scd_pkg::REG_GAIN_RIGHT: begin
               cfg_ff.gain_right <= csr_wdata;
            end
            scd_pkg::REG_GAIN_LEFT: begin
               cfg_ff.gain_left <= csr_wdata;
            end
            scd_pkg::REG_GAIN_FRONT: begin
               cfg_ff.gain_front <= csr_wdata;
            end
            scd_pkg::REG_MOVE_THRESHOLD_SQ: begin
               cfg_ff.move_threshold_sq <= csr_wdata;
            end
            scd_pkg::REG_MIN_INTERVAL_MS: begin
               cfg_ff.min_interval_ms <= csr_wdata;
            end
         endcase
      end
   end

   scd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   scd_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .ADC_BITS      (ADC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .cfg          (cfg_ff),
      .right_sample (req_right_sample),
      .left_sample  (req_left_sample),
      .front_sample (req_front_sample),
      .now_ms       (req_now_ms),
      .status       (status),
      .step_seen    (rsp_step_seen),
      .step_total   (rsp_step_total),
      .walk_speed   (rsp_walk_speed)
   );

   a_count_follows_step: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_step_total == $past(rsp_step_total) + 16'(rsp_step_seen))
      else $error("step total does not follow step flag");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in flight");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !rsp_valid || !rsp_stall)
      else $error("result updated while stalled");

endmodule

### hw/rtl/scd_divider.sv
// Restoring divider: fixed rate numerator over a 32 bit interval, one quotient bit per cycle.
module scd_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [scd_pkg::TIME_W-1:0]      divisor,
   output logic                            done,
   output logic [scd_pkg::QUOT_W-1:0]      quotient
);

   logic                                busy_ff;
   logic                                done_ff;
   logic [scd_pkg::COUNT_W-1:0]         count_ff;
   logic [scd_pkg::QUOT_W-1:0]          rem_ff;
   logic [scd_pkg::QUOT_W-1:0]          quot_ff;
   logic [scd_pkg::QUOT_W:0]            trial;
   logic [scd_pkg::QUOT_W:0]            diff;
   logic                                fits;

   assign trial = {rem_ff, scd_pkg::RATE_NUM[count_ff]};
   assign fits  = {{(scd_pkg::TIME_W-scd_pkg::QUOT_W-1){1'b0}}, trial} >= divisor;
   assign diff  = trial - divisor[scd_pkg::QUOT_W:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= scd_pkg::COUNT_W'(scd_pkg::QUOT_W - 1);
         end else if (busy_ff) begin
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               count_ff <= count_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= fits ? diff[scd_pkg::QUOT_W-1:0] : trial[scd_pkg::QUOT_W-1:0];
         quot_ff <= {quot_ff[scd_pkg::QUOT_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

### hw/rtl/scd_datapath.sv
// Datapath: sample scaling, centre point, history line, step decision, cadence and speed state.
module scd_datapath #(
   parameter int HISTORY_DEPTH = scd_pkg::HISTORY_DEPTH_DEF,
   parameter int ADC_BITS      = scd_pkg::ADC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  scd_pkg::cmd_type                  cmd,
   input  scd_pkg::cfg_type                  cfg,
   input  logic [scd_pkg::SAMPLE_W-1:0]      right_sample,
   input  logic [scd_pkg::SAMPLE_W-1:0]      left_sample,
   input  logic [scd_pkg::SAMPLE_W-1:0]      front_sample,
   input  logic [scd_pkg::TIME_W-1:0]        now_ms,
   output scd_pkg::status_type               status,
   output logic                              step_seen,
   output logic [scd_pkg::WORD_W-1:0]        step_total,
   output logic [scd_pkg::WORD_W-1:0]        walk_speed
);

   localparam int MaskBits = (ADC_BITS < scd_pkg::SAMPLE_W) ? ADC_BITS : scd_pkg::SAMPLE_W;
   localparam logic [scd_pkg::SAMPLE_W-1:0] AdcMask =
      scd_pkg::SAMPLE_W'((64'd1 << MaskBits) - 64'd1);

   logic [scd_pkg::SAMPLE_W-1:0]              right_ff, left_ff, front_ff;
   logic [scd_pkg::TIME_W-1:0]                now_ff;

   logic signed [scd_pkg::DIFF_W-1:0]         d_right, d_left, d_front;
   logic signed [scd_pkg::PROD_W-1:0]         p_right, p_left, p_front;
   logic signed [scd_pkg::SCALED_W-1:0]       r_ff, l_ff, f_ff;

   logic signed [scd_pkg::WIDE_W-1:0]         diff_rl, sum_rl, half_rl, y_pre;
   logic signed [scd_pkg::MIX_W-1:0]          mix_in, mix_ff;
   logic signed [scd_pkg::WORD_W-1:0]         x_ff, y_ff;
   logic [scd_pkg::TIME_W-1:0]                interval_ff;

   logic signed [scd_pkg::DELTA_W-1:0]        dx, dy;
   logic signed [2*scd_pkg::DELTA_W-1:0]      dx_sq, dy_sq;
   logic [scd_pkg::SQ_W-1:0]                  sq_x_ff, sq_y_ff;
   logic [scd_pkg::DECAY_W-1:0]               decay_prod_ff;
   logic [scd_pkg::DSQ_W-1:0]                 dsq;

   logic                                      step_ff, decay_ff;

   logic                                      div_done;
   logic [scd_pkg::QUOT_W-1:0]                quotient;
   logic [scd_pkg::WORD_W-1:0]                cad_new_in, cad_new_ff;
   logic [25:0]                               fifth_prod;
   logic [14:0]                               a_ff;
   logic [30:0]                               v_prod;
   logic [scd_pkg::WORD_W-1:0]                spd_new_ff;

   logic signed [scd_pkg::WORD_W-1:0]         hx_ff [HISTORY_DEPTH];
   logic signed [scd_pkg::WORD_W-1:0]         hy_ff [HISTORY_DEPTH];
   logic [scd_pkg::WORD_W-1:0]                counter_ff, cadence_ff, speed_ff;
   logic [scd_pkg::TIME_W-1:0]                last_step_ff;
   logic                                      seen_ff;

   // capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         right_ff <= right_sample & AdcMask;
         left_ff  <= left_sample & AdcMask;
         front_ff <= front_sample & AdcMask;
         now_ff   <= now_ms;
      end
   end

   // offset and gain
   assign d_right = $signed({1'b0, right_ff}) - $signed({1'b0, cfg.offset_right});
   assign d_left  = $signed({1'b0, left_ff}) - $signed({1'b0, cfg.offset_left});
   assign d_front = $signed({1'b0, front_ff}) - $signed({1'b0, cfg.offset_front});
   assign p_right = d_right * $signed({1'b0, cfg.gain_right});
   assign p_left  = d_left * $signed({1'b0, cfg.gain_left});
   assign p_front = d_front * $signed({1'b0, cfg.gain_front});

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         r_ff <= p_right[28:4];
         l_ff <= p_left[28:4];
         f_ff <= p_front[28:4];
      end
   end

   // centre point
   assign diff_rl = scd_pkg::WIDE_W'(r_ff) - scd_pkg::WIDE_W'(l_ff);
   assign sum_rl  = scd_pkg::WIDE_W'(r_ff) + scd_pkg::WIDE_W'(l_ff);
   assign half_rl = sum_rl >>> 1;
   assign y_pre   = scd_pkg::WIDE_W'(f_ff) - half_rl;
   assign mix_in  = diff_rl * $signed({1'b0, scd_pkg::COS30_Q12});

   always_ff @(posedge clock) begin
      if (cmd.mix) begin
         mix_ff <= mix_in;
         y_ff   <= scd_pkg::sat16s(y_pre);
      end
      if (cmd.point) begin
         x_ff        <= scd_pkg::sat16s(mix_ff[scd_pkg::MIX_W-1:12]);
         interval_ff <= now_ff - last_step_ff;
      end
   end

   // squared shift against the oldest history point
   assign dx    = scd_pkg::DELTA_W'(x_ff) - scd_pkg::DELTA_W'(hx_ff[0]);
   assign dy    = scd_pkg::DELTA_W'(y_ff) - scd_pkg::DELTA_W'(hy_ff[0]);
   assign dx_sq = dx * dx;
   assign dy_sq = dy * dy;

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_x_ff       <= dx_sq[scd_pkg::SQ_W-1:0];
         sq_y_ff       <= dy_sq[scd_pkg::SQ_W-1:0];
         decay_prod_ff <= scd_pkg::DECAY_W'(interval_ff) * scd_pkg::DECAY_W'(cadence_ff);
      end
   end

   assign dsq = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};
   assign status.step_now =
      (dsq > scd_pkg::DSQ_W'({cfg.move_threshold_sq, 12'd0})) &&
      (interval_ff >= scd_pkg::TIME_W'(cfg.min_interval_ms));

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         step_ff  <= status.step_now;
         decay_ff <= decay_prod_ff > scd_pkg::DECAY_LIMIT;
      end
   end

   // cadence
   scd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .divisor  (interval_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign status.div_done = div_done;

   assign cad_new_in = (quotient[scd_pkg::QUOT_W-1:scd_pkg::WORD_W] != '0) ?
                       16'hffff : quotient[scd_pkg::WORD_W-1:0];
   assign fifth_prod = 26'(scd_pkg::FIFTH_Q12) * 26'(cad_new_in);
   assign v_prod     = 31'(a_ff) * 31'(cad_new_ff);

   always_ff @(posedge clock) begin
      if (cmd.speed_a) begin
         cad_new_ff <= cad_new_in;
         a_ff       <= 15'(fifth_prod[25:12]) + scd_pkg::HALF_Q12;
      end
      if (cmd.speed_v) begin
         spd_new_ff <= scd_pkg::sat16u(v_prod[30:12]);
      end
   end

   // walking state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hx_ff[i] <= '0;
            hy_ff[i] <= '0;
         end
         counter_ff   <= '0;
         cadence_ff   <= '0;
         speed_ff     <= '0;
         last_step_ff <= '0;
         seen_ff      <= 1'b0;
      end else if (cmd.commit) begin
         for (int i = 0; i + 1 < HISTORY_DEPTH; i++) begin
            hx_ff[i] <= hx_ff[i+1];
            hy_ff[i] <= hy_ff[i+1];
         end
         hx_ff[HISTORY_DEPTH-1] <= x_ff;
         hy_ff[HISTORY_DEPTH-1] <= y_ff;
         seen_ff <= step_ff;
         if (step_ff) begin
            counter_ff   <= counter_ff + 1'b1;
            cadence_ff   <= cad_new_ff;
            speed_ff     <= spd_new_ff;
            last_step_ff <= now_ff;
         end else if (decay_ff) begin
            speed_ff <= '0;
         end
      end
   end

   assign step_seen  = seen_ff;
   assign step_total = counter_ff;
   assign walk_speed = speed_ff;

endmodule

### hw/rtl/scd_controller.sv
// Controller: sequences one item through the datapath and owns both handshakes.
module scd_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  scd_pkg::status_type   status,
   output scd_pkg::cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCALE,
      ST_MIX,
      ST_POINT,
      ST_SQUARE,
      ST_DECIDE,
      ST_DIVIDE,
      ST_SPEED_A,
      ST_SPEED_V,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_MIX;
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_POINT;
         end
         ST_POINT: begin
            cmd.point = 1'b1;
            state_in  = ST_SQUARE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.step_now) begin
               cmd.start_div = 1'b1;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_SPEED_A;
            end
         end
         ST_SPEED_A: begin
            cmd.speed_a = 1'b1;
            state_in    = ST_SPEED_V;
         end
         ST_SPEED_V: begin
            cmd.speed_v = 1'b1;
            state_in    = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
